// ===== hw/rtl/srt_pkg.sv =====
`timescale 1ns / 1ps

package srt_pkg;

  localparam int MAX_SEGMENTS        = 8;
  localparam int START_PAYLOAD_BYTES = 20;
  localparam int CONT_PAYLOAD_BYTES  = 23;
  localparam int BUF_BYTES = START_PAYLOAD_BYTES + (MAX_SEGMENTS - 2) * CONT_PAYLOAD_BYTES;

  localparam int BUF_AW = $clog2(BUF_BYTES);
  localparam int LEN_W  = $clog2(BUF_BYTES + 1);
  localparam int WP_W   = $clog2(BUF_BYTES) + 1;   // saturates above any buffer index
  localparam int SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int MISS_W = MAX_SEGMENTS - 1;

  localparam logic [7:0] INV_TN_DEVICE = 8'hff;
  localparam logic [7:0] INV_TN_PROV   = 8'h7f;
  localparam logic [7:0] RESEND_NONE   = 8'hff;
  localparam logic [7:0] CRC_INIT      = 8'hff;
  localparam logic [7:0] CRC_POLY      = 8'he0;

  typedef enum logic [1:0] {
    REQ_SEG  = 2'd0,
    REQ_READ = 2'd1,
    REQ_OPEN = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_STORED    = 4'd0,
    ST_DUP       = 4'd1,
    ST_RESEND    = 4'd2,
    ST_FOREIGN   = 4'd3,
    ST_MALFORMED = 4'd4,
    ST_COMPLETE  = 4'd5,
    ST_FCS_ERR   = 4'd6,
    ST_READ      = 4'd7,
    ST_RESET     = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    FMT_START = 2'd0,
    FMT_ACK   = 2'd1,
    FMT_CONT  = 2'd2,
    FMT_CTRL  = 2'd3
  } fmt_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch request fields
    logic exec;       // apply one request to the reassembly state
    logic load_exec;  // register result of exec
    logic load_read;  // register buffer read result
    logic crc_run;    // one CRC beat
    logic finish;     // close transaction, register result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;
    logic has_result;
    logic need_crc;
    logic crc_done;
  } sts_t;

endpackage

// ===== hw/rtl/srt_ram.sv =====
`timescale 1ns / 1ps

module srt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 158
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/srt_ctrl.sv =====
`timescale 1ns / 1ps

module srt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  output logic          done_o,
  input  srt_pkg::sts_t sts_i,
  output srt_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDOUT,
    S_CRC
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_read) begin
          state_d = S_RDOUT;
        end else if (sts_i.need_crc) begin
          state_d = S_CRC;
        end else begin
          cmd_o.load_exec = sts_i.has_result;
          done_d          = sts_i.has_result;
          state_d         = S_IDLE;
        end
      end
      S_RDOUT: begin
        cmd_o.load_read = 1'b1;
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_CRC: begin
        if (sts_i.crc_done) begin
          cmd_o.finish = 1'b1;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          cmd_o.crc_run = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result strobe outside idle");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == S_EXEC)
    else $error("accepted request not executed");

  a_crc_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CRC && sts_i.crc_done) |=> done_q)
    else $error("CRC end without result");

endmodule

// ===== hw/rtl/srt_dp.sv =====
`timescale 1ns / 1ps

module srt_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  srt_pkg::cmd_t cmd_i,
  output srt_pkg::sts_t sts_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic [1:0]    req_type_i,
  input  logic [7:0]    seg_byte_i,
  input  logic          seg_first_i,
  input  logic          seg_last_i,
  input  logic [7:0]    read_index_i,
  output logic [3:0]    status_o,
  output logic [7:0]    transaction_number_o,
  output logic [7:0]    message_length_o,
  output logic          send_ack_o,
  output logic [7:0]    ack_number_o,
  output logic [7:0]    read_data_o,
  output logic [7:0]    computed_fcs_o
);

  localparam int BP_W = 3;
  localparam logic [BP_W-1:0] BP_MAX = 3'd5;
  localparam logic [BP_W-1:0] BP_LEN_HI = 3'd2;
  localparam logic [BP_W-1:0] BP_LEN_LO = 3'd3;
  localparam logic [BP_W-1:0] BP_FCS = 3'd4;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_HDR,
    ACT_START,
    ACT_CONT,
    ACT_SKIP
  } act_e;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ srt_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [srt_pkg::WP_W-1:0] seg_offset(
      input logic [srt_pkg::SEG_W-1:0] seg);
    return srt_pkg::WP_W'(srt_pkg::START_PAYLOAD_BYTES
                          + (int'(seg) - 1) * srt_pkg::CONT_PAYLOAD_BYTES);
  endfunction

  // latched request
  srt_pkg::req_e rq_q;
  logic [7:0]    b_q;
  logic          first_q;
  logic          last_q;
  logic [7:0]    ridx_q;

  // reassembly state
  logic                        role_q;
  logic [7:0]                  cur_tx_q, cur_tx_d;
  logic [7:0]                  prev_tx_q, prev_tx_d;
  logic [srt_pkg::LEN_W-1:0]   decl_q, decl_d;
  logic [7:0]                  efcs_q, efcs_d;
  logic [srt_pkg::SEG_W-1:0]   last_idx_q, last_idx_d;
  logic [srt_pkg::MISS_W-1:0]  miss_q, miss_d;
  logic [BP_W-1:0]             bp_q, bp_d;
  act_e                        act_q, act_d;
  logic [srt_pkg::SEG_W-1:0]   seg_idx_q, seg_idx_d;
  logic [srt_pkg::WP_W-1:0]    wp_q, wp_d;
  logic [7:0]                  tn_q, tn_d;
  logic [5:0]                  ctrl_hi_q, ctrl_hi_d;
  logic                        pend_big_q, pend_big_d;
  logic [7:0]                  pend_lo_q, pend_lo_d;
  srt_pkg::status_e            verdict_q, verdict_d;
  logic [srt_pkg::BUF_BYTES-1:0] valid_q;

  // CRC walk
  logic [7:0]                crc_q;
  logic [srt_pkg::LEN_W-1:0] crc_idx_q;
  logic                      crc_pend_q;
  logic                      crc_issue;

  // buffer port
  logic                       wr_req;
  logic [srt_pkg::BUF_AW-1:0] waddr;
  logic [srt_pkg::BUF_AW-1:0] raddr;
  logic                       rd_ok_d, rd_ok_q;
  logic [7:0]                 ram_rdata;
  logic [7:0]                 rd_byte;

  // exec result
  srt_pkg::status_e res_status;
  logic [7:0]       res_tn;
  logic             res_ack;
  logic [7:0]       res_ackn;
  logic             has_result;
  logic             need_crc;

  logic [7:0]       inv_tn;
  logic [5:0]       seg_num;
  srt_pkg::fmt_e    fmt;
  logic [BP_W-1:0]  cur;
  logic             wp_inc;
  logic [7:0]       fcs_out;
  logic             fcs_ok;

  assign inv_tn  = role_q ? srt_pkg::INV_TN_PROV : srt_pkg::INV_TN_DEVICE;
  assign seg_num = b_q[7:2];
  assign fmt     = srt_pkg::fmt_e'(b_q[1:0]);

  always_comb begin
    cur_tx_d   = cur_tx_q;
    prev_tx_d  = prev_tx_q;
    decl_d     = decl_q;
    efcs_d     = efcs_q;
    last_idx_d = last_idx_q;
    miss_d     = miss_q;
    bp_d       = bp_q;
    act_d      = act_q;
    seg_idx_d  = seg_idx_q;
    wp_d       = wp_q;
    tn_d       = tn_q;
    ctrl_hi_d  = ctrl_hi_q;
    pend_big_d = pend_big_q;
    pend_lo_d  = pend_lo_q;
    verdict_d  = verdict_q;
    wr_req     = 1'b0;
    wp_inc     = 1'b0;
    waddr      = '0;
    res_status = srt_pkg::ST_MALFORMED;
    res_tn     = '0;
    res_ack    = 1'b0;
    res_ackn   = '0;
    has_result = 1'b0;
    need_crc   = 1'b0;
    cur        = '0;

    case (rq_q)
      srt_pkg::REQ_OPEN: begin
        cur_tx_d   = inv_tn;
        prev_tx_d  = inv_tn;
        act_d      = ACT_NONE;
        bp_d       = '0;
        has_result = 1'b1;
        res_status = srt_pkg::ST_RESET;
      end
      srt_pkg::REQ_SEG: begin
        if (first_q) begin
          act_d     = ACT_HDR;
          bp_d      = '0;
          tn_d      = '0;
          verdict_d = srt_pkg::ST_MALFORMED;
        end
        cur = bp_d;
        case (act_d)
          ACT_HDR: begin
            if (cur == '0) begin
              tn_d = b_q;
            end else begin
              // control byte decode
              ctrl_hi_d = seg_num;
              if (fmt == srt_pkg::FMT_ACK || fmt == srt_pkg::FMT_CTRL) begin
                verdict_d = srt_pkg::ST_FOREIGN;
                act_d     = ACT_SKIP;
              end else if (tn_d != srt_pkg::RESEND_NONE && tn_d == prev_tx_q) begin
                verdict_d = srt_pkg::ST_RESEND;
                act_d     = ACT_SKIP;
              end else if (fmt == srt_pkg::FMT_START) begin
                if (tn_d == cur_tx_q) begin
                  verdict_d = srt_pkg::ST_DUP;
                  act_d     = ACT_SKIP;
                end else begin
                  verdict_d = srt_pkg::ST_MALFORMED;
                  act_d     = ACT_START;
                end
              end else if (tn_d != cur_tx_q) begin
                verdict_d = srt_pkg::ST_FOREIGN;
                act_d     = ACT_SKIP;
              end else if (seg_num == '0 || int'(seg_num) >= srt_pkg::MAX_SEGMENTS) begin
                verdict_d = srt_pkg::ST_MALFORMED;
                act_d     = ACT_SKIP;
              end else if (!miss_q[srt_pkg::SEG_W'(seg_num) - 1'b1]) begin
                verdict_d = srt_pkg::ST_DUP;
                act_d     = ACT_SKIP;
              end else begin
                seg_idx_d = srt_pkg::SEG_W'(seg_num);
                wp_d      = seg_offset(srt_pkg::SEG_W'(seg_num));
                verdict_d = srt_pkg::ST_STORED;
                act_d     = ACT_CONT;
              end
            end
          end
          ACT_START: begin
            if (cur == BP_LEN_HI) begin
              pend_big_d = (b_q != '0);
              pend_lo_d  = '0;
            end else if (cur == BP_LEN_LO) begin
              pend_lo_d = pend_lo_q | b_q;
            end else if (cur == BP_FCS) begin
              if (pend_big_q || int'(pend_lo_q) > srt_pkg::BUF_BYTES
                  || int'(ctrl_hi_q) >= srt_pkg::MAX_SEGMENTS) begin
                verdict_d = srt_pkg::ST_MALFORMED;
                act_d     = ACT_SKIP;
              end else begin
                cur_tx_d   = tn_d;
                decl_d     = srt_pkg::LEN_W'(pend_lo_q);
                efcs_d     = b_q;
                last_idx_d = srt_pkg::SEG_W'(ctrl_hi_q);
                for (int i = 0; i < srt_pkg::MISS_W; i++) begin
                  miss_d[i] = (i < int'(ctrl_hi_q));
                end
                wp_d       = '0;
                verdict_d  = srt_pkg::ST_STORED;
              end
            end else if (cur > BP_FCS) begin
              wr_req = 1'b1;
            end
          end
          ACT_CONT: begin
            // last segment: bytes beyond the declared length only count
            if (seg_idx_q == last_idx_q && wp_q >= srt_pkg::WP_W'(decl_q)) begin
              wp_inc = 1'b1;
            end else begin
              wr_req = 1'b1;
            end
          end
          default: begin
          end
        endcase

        if (wr_req) begin
          wp_inc = 1'b1;
          if (int'(wp_d) >= srt_pkg::BUF_BYTES) begin
            wr_req = 1'b0;
          end else begin
            waddr = srt_pkg::BUF_AW'(wp_d);
          end
        end
        if (wp_inc && wp_d != '1) begin
          wp_d = wp_d + 1'b1;
        end
        if (act_d != ACT_NONE && bp_d < BP_MAX) begin
          bp_d = bp_d + 1'b1;
        end

        if (last_q) begin
          has_result = 1'b1;
          res_tn     = tn_d;
          case (act_d)
            ACT_NONE: begin
              res_tn = '0;
            end
            ACT_START: begin
              if (cur < BP_FCS) begin
                res_status = srt_pkg::ST_MALFORMED;
              end else if (miss_d == '0) begin
                need_crc = 1'b1;
              end else begin
                res_status = srt_pkg::ST_STORED;
              end
            end
            ACT_CONT: begin
              if (seg_idx_d == last_idx_d && wp_d != srt_pkg::WP_W'(decl_d)) begin
                res_status = srt_pkg::ST_MALFORMED;
              end else begin
                miss_d[seg_idx_d - 1'b1] = 1'b0;
                if (miss_d == '0) begin
                  need_crc = 1'b1;
                end else begin
                  res_status = srt_pkg::ST_STORED;
                end
              end
            end
            ACT_SKIP: begin
              res_status = verdict_d;
              if (verdict_d == srt_pkg::ST_RESEND) begin
                res_ack  = 1'b1;
                res_ackn = prev_tx_d;
              end
            end
            default: begin
              res_status = srt_pkg::ST_MALFORMED;
            end
          endcase
          act_d = ACT_NONE;
          bp_d  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // read port: CRC walk on crc_run, host read otherwise
  always_comb begin
    crc_issue = (crc_idx_q < decl_q);
    if (cmd_i.crc_run) begin
      raddr   = srt_pkg::BUF_AW'(crc_idx_q);
      rd_ok_d = crc_issue && valid_q[raddr];
    end else if (int'(ridx_q) < srt_pkg::BUF_BYTES) begin
      raddr   = srt_pkg::BUF_AW'(ridx_q);
      rd_ok_d = valid_q[raddr];
    end else begin
      raddr   = '0;
      rd_ok_d = 1'b0;
    end
  end

  assign rd_byte = rd_ok_q ? ram_rdata : 8'h00;
  assign fcs_out = ~crc_q;
  assign fcs_ok  = (fcs_out == efcs_q);

  srt_ram #(
    .WIDTH(8),
    .DEPTH(srt_pkg::BUF_BYTES)
  ) u_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.exec && wr_req),
    .waddr_i(waddr),
    .wdata_i(b_q),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rq_q    <= srt_pkg::req_e'(req_type_i);
      b_q     <= seg_byte_i;
      first_q <= seg_first_i;
      last_q  <= seg_last_i;
      ridx_q  <= read_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q     <= 1'b0;
      cur_tx_q   <= srt_pkg::INV_TN_DEVICE;
      prev_tx_q  <= srt_pkg::INV_TN_DEVICE;
      decl_q     <= '0;
      efcs_q     <= '0;
      last_idx_q <= '0;
      miss_q     <= '0;
      bp_q       <= '0;
      act_q      <= ACT_NONE;
      seg_idx_q  <= '0;
      wp_q       <= '0;
      tn_q       <= '0;
      ctrl_hi_q  <= '0;
      pend_big_q <= 1'b0;
      pend_lo_q  <= '0;
      verdict_q  <= srt_pkg::ST_STORED;
      valid_q    <= '0;
      crc_q      <= srt_pkg::CRC_INIT;
      crc_idx_q  <= '0;
      crc_pend_q <= 1'b0;
      rd_ok_q    <= 1'b0;
    end else begin
      rd_ok_q <= rd_ok_d;
      if (cfg_we_i) begin
        role_q <= cfg_wdata_i;
      end
      if (cmd_i.exec) begin
        cur_tx_q   <= cur_tx_d;
        prev_tx_q  <= prev_tx_d;
        decl_q     <= decl_d;
        efcs_q     <= efcs_d;
        last_idx_q <= last_idx_d;
        miss_q     <= miss_d;
        bp_q       <= bp_d;
        act_q      <= act_d;
        seg_idx_q  <= seg_idx_d;
        wp_q       <= wp_d;
        tn_q       <= tn_d;
        ctrl_hi_q  <= ctrl_hi_d;
        pend_big_q <= pend_big_d;
        pend_lo_q  <= pend_lo_d;
        verdict_q  <= verdict_d;
        if (wr_req) begin
          valid_q[waddr] <= 1'b1;
        end
        crc_q      <= srt_pkg::CRC_INIT;
        crc_idx_q  <= '0;
        crc_pend_q <= 1'b0;
      end
      if (cmd_i.crc_run) begin
        crc_pend_q <= crc_issue;
        if (crc_issue) begin
          crc_idx_q <= crc_idx_q + 1'b1;
        end
        if (crc_pend_q) begin
          crc_q <= crc8_step(crc_q, rd_byte);
        end
      end
      if (cmd_i.finish && fcs_ok) begin
        prev_tx_q <= cur_tx_q;
        cur_tx_q  <= inv_tn;
      end
    end
  end

  // result registers
  logic [3:0] status_q;
  logic [7:0] tn_out_q;
  logic [7:0] mlen_q;
  logic       ack_q;
  logic [7:0] ackn_q;
  logic [7:0] rdata_q;
  logic [7:0] fcs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_exec) begin
      status_q <= res_status;
      tn_out_q <= res_tn;
      mlen_q   <= 8'(decl_d);
      ack_q    <= res_ack;
      ackn_q   <= res_ackn;
      rdata_q  <= '0;
      fcs_q    <= '0;
    end else if (cmd_i.load_read) begin
      status_q <= srt_pkg::ST_READ;
      tn_out_q <= '0;
      mlen_q   <= 8'(decl_q);
      ack_q    <= 1'b0;
      ackn_q   <= '0;
      rdata_q  <= rd_byte;
      fcs_q    <= '0;
    end else if (cmd_i.finish) begin
      status_q <= fcs_ok ? srt_pkg::ST_COMPLETE : srt_pkg::ST_FCS_ERR;
      tn_out_q <= tn_q;
      mlen_q   <= 8'(decl_q);
      ack_q    <= fcs_ok;
      ackn_q   <= fcs_ok ? cur_tx_q : 8'h00;
      rdata_q  <= '0;
      fcs_q    <= fcs_out;
    end
  end

  assign status_o             = status_q;
  assign transaction_number_o = tn_out_q;
  assign message_length_o     = mlen_q;
  assign send_ack_o           = ack_q;
  assign ack_number_o         = ackn_q;
  assign read_data_o          = rdata_q;
  assign computed_fcs_o       = fcs_q;

  assign sts_o.is_read    = (rq_q == srt_pkg::REQ_READ);
  assign sts_o.has_result = has_result;
  assign sts_o.need_crc   = need_crc;
  assign sts_o.crc_done   = !crc_issue && !crc_pend_q;

  a_crc_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_idx_q <= decl_q)
    else $error("CRC walk past declared length");

  a_bp_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bp_q <= BP_MAX)
    else $error("byte position out of range");

  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && rq_q == srt_pkg::REQ_OPEN) |=> (cur_tx_q == prev_tx_q))
    else $error("link open left transaction numbers apart");

endmodule

// ===== hw/rtl/segmented_transaction_reassembly_unit.sv =====
`timescale 1ns / 1ps

// Reassembles segmented provisioning transactions, one segment byte per
// request. A request is taken when start is high and busy is low; its result,
// if it has one, appears on the result ports for exactly one cycle with
// result_valid_o high. There is no backpressure: the receiver must take every
// result beat the cycle it is shown. A segment byte, a link open or an ignored
// code passes through capture and execute, and busy drops in the cycle the
// result is shown, so the next request can go in then. A buffer read adds a
// readout step for the registered RAM read. A segment that completes the
// message runs CRC-8 over the buffer, one byte per cycle through the single
// RAM read port, for a declared length of up to 158 bytes. No clearing pass
// after reset: per-byte valid flops make unwritten buffer bytes read as zero.
// provisioner_role is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, which the block does not enforce.
module segmented_transaction_reassembly_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic [1:0] req_type_i,
  input  logic [7:0] seg_byte_i,
  input  logic       seg_first_i,
  input  logic       seg_last_i,
  input  logic [7:0] read_index_i,
  output logic       result_valid_o,
  output logic [3:0] status_o,
  output logic [7:0] transaction_number_o,
  output logic [7:0] message_length_o,
  output logic       send_ack_o,
  output logic [7:0] ack_number_o,
  output logic [7:0] read_data_o,
  output logic [7:0] computed_fcs_o
);

  srt_pkg::cmd_t cmd;
  srt_pkg::sts_t sts;

  // sequencing: capture, execute, optional read / CRC walk, result beat
  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .done_o (result_valid_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // reassembly state, message buffer, CRC unit and result registers
  srt_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .req_type_i          (req_type_i),
    .seg_byte_i          (seg_byte_i),
    .seg_first_i         (seg_first_i),
    .seg_last_i          (seg_last_i),
    .read_index_i        (read_index_i),
    .status_o            (status_o),
    .transaction_number_o(transaction_number_o),
    .message_length_o    (message_length_o),
    .send_ack_o          (send_ack_o),
    .ack_number_o        (ack_number_o),
    .read_data_o         (read_data_o),
    .computed_fcs_o      (computed_fcs_o)
  );

endmodule
